>>> rtl/multi_level_priority_queue_assert.svh
// Assertion helpers for the priority queue block.
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLPQ_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mlpq same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MLPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mlpq next-cycle check failed");

`endif

>>> rtl/mlpq_pkg.sv
`timescale 1ns / 1ps

package mlpq_pkg;

    // Sizing
    localparam int LEVELS     = 10;
    localparam int POOL_DEPTH = 1024;
    localparam int KEY_WIDTH  = 32;

    localparam int IDX_W    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W    = $clog2(POOL_DEPTH + 1);
    localparam int LIDX_W   = $clog2(LEVELS);
    localparam int LEVEL_W  = 4;
    localparam int FKEY_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LIDX_W-1:0] lidx_t;

    // Command and status codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Channel beats
    typedef struct packed {
        logic               command;
        logic [LEVEL_W-1:0] level;
        logic [FKEY_W-1:0]  key;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FKEY_W-1:0]   key_out;
        logic [LEVEL_W-1:0]  level_out;
    } out_beat_t;

    // Level table update and status
    typedef struct packed {
        logic  enq;
        logic  deq;
        lidx_t idx;
        idx_t  entry;
        idx_t  next_head;
    } lvl_op_t;

    typedef struct packed {
        logic  any;
        lidx_t found;
        idx_t  head_found;
        idx_t  tail_sel;
        logic  nonempty_sel;
    } lvl_stat_t;

    // Free list update and status
    typedef struct packed {
        logic alloc;
        logic rel;
        idx_t rel_entry;
        idx_t link_rd;
    } fl_op_t;

    typedef struct packed {
        idx_t head;
        logic empty;
        logic full;
    } fl_stat_t;

    // Key as stored in the pool
    function automatic logic [KEY_WIDTH-1:0] key_store(input logic [FKEY_W-1:0] k);
        logic [63:0] w;
        w = {32'b0, k};
        return w[KEY_WIDTH-1:0];
    endfunction

    // Stored key back to the result field
    function automatic logic [FKEY_W-1:0] key_trunc(input logic [KEY_WIDTH-1:0] k);
        logic [63:0] w;
        w = 64'(k);
        return w[FKEY_W-1:0];
    endfunction

    // Link of an entry that has never been handed out
    function automatic idx_t next_idx(input idx_t n);
        if (int'(n) + 1 < POOL_DEPTH) begin
            return idx_t'(int'(n) + 1);
        end
        return '0;
    endfunction

endpackage

>>> rtl/mlpq_ram.sv
`timescale 1ns / 1ps

module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mlpq_levels.sv
`timescale 1ns / 1ps

module mlpq_levels (
    input  logic                aclk,
    input  logic                aresetn,
    input  mlpq_pkg::lvl_op_t   op,
    input  mlpq_pkg::lidx_t     sel,
    output mlpq_pkg::lvl_stat_t stat
);

    mlpq_pkg::idx_t                head_reg [mlpq_pkg::LEVELS];
    mlpq_pkg::idx_t                tail_reg [mlpq_pkg::LEVELS];
    logic [mlpq_pkg::LEVELS-1:0]   nonempty_reg;
    mlpq_pkg::lidx_t               found;

    // Lowest-numbered non-empty level
    always_comb begin
        found = '0;
        for (int l = mlpq_pkg::LEVELS - 1; l >= 0; l--) begin
            if (nonempty_reg[l]) begin
                found = mlpq_pkg::lidx_t'(l);
            end
        end
    end

    always_comb begin
        stat.any          = |nonempty_reg;
        stat.found        = found;
        stat.head_found   = head_reg[found];
        stat.tail_sel     = tail_reg[sel];
        stat.nonempty_sel = nonempty_reg[sel];
    end

    // Append on enqueue, pop head on dequeue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg <= '0;
            for (int l = 0; l < mlpq_pkg::LEVELS; l++) begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
            end
        end else begin
            if (op.enq) begin
                if (!nonempty_reg[op.idx]) begin
                    head_reg[op.idx] <= op.entry;
                end
                tail_reg[op.idx]     <= op.entry;
                nonempty_reg[op.idx] <= 1'b1;
            end
            if (op.deq) begin
                if (head_reg[op.idx] == tail_reg[op.idx]) begin
                    nonempty_reg[op.idx] <= 1'b0;
                end else begin
                    head_reg[op.idx] <= op.next_head;
                end
            end
        end
    end

endmodule

>>> rtl/mlpq_free.sv
`timescale 1ns / 1ps

module mlpq_free (
    input  logic               aclk,
    input  logic               aresetn,
    input  mlpq_pkg::fl_op_t   op,
    output mlpq_pkg::fl_stat_t stat
);

    mlpq_pkg::idx_t free_head_reg;
    mlpq_pkg::cnt_t count_reg;
    mlpq_pkg::cnt_t hwm_reg;
    logic           fresh;

    // Entries at or above the high-water mark were never handed out, so
    // their link is still the power-up chain and the link memory is stale.
    assign fresh = mlpq_pkg::cnt_t'(free_head_reg) >= hwm_reg;

    assign stat.head  = free_head_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == mlpq_pkg::cnt_t'(mlpq_pkg::POOL_DEPTH));

    // Pop on allocate, push on release
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            count_reg     <= mlpq_pkg::cnt_t'(mlpq_pkg::POOL_DEPTH);
            hwm_reg       <= '0;
        end else begin
            if (op.alloc) begin
                free_head_reg <= fresh ? mlpq_pkg::next_idx(free_head_reg) : op.link_rd;
                count_reg     <= count_reg - 1'b1;
                if (fresh) begin
                    hwm_reg <= hwm_reg + 1'b1;
                end
            end
            if (op.rel) begin
                free_head_reg <= op.rel_entry;
                if (!stat.full) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/multi_level_priority_queue.sv
// Strict-priority queue over a shared pool of linked entries. Each beat on s_
// is an enqueue (key at a level) or a dequeue (head of the lowest-numbered
// non-empty level), and gives exactly one result beat on m_ with a status of
// done, pool full or queue empty; full and empty never block. On accept the
// key and link memories are read at the free-list head or at the selected
// level's head; when the item fires, the links are written back and the
// level and free-list registers updated. One item is in flight at a time; a
// new item is taken while the previous result still waits on m_. Firing
// waits only when m_ still holds an untaken beat. No clearing pass is needed
// after reset: untouched entries are tracked by a high-water mark.
`timescale 1ns / 1ps

`include "multi_level_priority_queue_assert.svh"

module multi_level_priority_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mlpq_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mlpq_pkg::out_beat_t m_data
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                          state_reg;
    mlpq_pkg::in_beat_t              item_reg;
    logic                            m_valid_reg;
    mlpq_pkg::out_beat_t             out_reg;
    mlpq_pkg::out_beat_t             out_next;

    logic                            accept;
    logic                            fire;
    logic                            is_deq;
    logic                            lvl_ok;
    logic                            enq_ok;
    logic                            deq_ok;
    mlpq_pkg::lidx_t                 sel;
    mlpq_pkg::idx_t                  raddr;
    mlpq_pkg::idx_t                  link_rd;
    logic [mlpq_pkg::KEY_WIDTH-1:0]  key_rd;
    logic                            link_we;
    mlpq_pkg::idx_t                  link_waddr;
    mlpq_pkg::idx_t                  link_wdata;

    mlpq_pkg::lvl_op_t               lvl_op;
    mlpq_pkg::lvl_stat_t             lvl_stat;
    mlpq_pkg::fl_op_t                fl_op;
    mlpq_pkg::fl_stat_t              fl_stat;

    // Handshake
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign fire    = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Decode of the item in flight
    assign is_deq = (item_reg.command == mlpq_pkg::CMD_DEQ);
    assign lvl_ok = int'(item_reg.level) < mlpq_pkg::LEVELS;
    assign sel    = is_deq ? lvl_stat.found : mlpq_pkg::lidx_t'(item_reg.level);
    assign enq_ok = fire && !is_deq && lvl_ok && !fl_stat.empty;
    assign deq_ok = fire && is_deq && lvl_stat.any;

    // Pool read address at accept: level head for dequeue, free head otherwise
    assign raddr = (s_data.command == mlpq_pkg::CMD_DEQ) ? lvl_stat.head_found
                                                         : fl_stat.head;

    // Link write: append behind the tail, or push the freed entry
    assign link_we    = (enq_ok && lvl_stat.nonempty_sel) || deq_ok;
    assign link_waddr = deq_ok ? lvl_stat.head_found : lvl_stat.tail_sel;
    assign link_wdata = (deq_ok && fl_stat.empty) ? '0 : fl_stat.head;

    mlpq_ram #(
        .WIDTH (mlpq_pkg::KEY_WIDTH),
        .DEPTH (mlpq_pkg::POOL_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (enq_ok),
        .waddr (fl_stat.head),
        .wdata (mlpq_pkg::key_store(item_reg.key)),
        .re    (accept),
        .raddr (raddr),
        .rdata (key_rd)
    );

    mlpq_ram #(
        .WIDTH (mlpq_pkg::IDX_W),
        .DEPTH (mlpq_pkg::POOL_DEPTH)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (raddr),
        .rdata (link_rd)
    );

    // Level table and free list updates
    always_comb begin
        lvl_op.enq       = enq_ok;
        lvl_op.deq       = deq_ok;
        lvl_op.idx       = sel;
        lvl_op.entry     = fl_stat.head;
        lvl_op.next_head = link_rd;

        fl_op.alloc      = enq_ok;
        fl_op.rel        = deq_ok;
        fl_op.rel_entry  = lvl_stat.head_found;
        fl_op.link_rd    = link_rd;
    end

    mlpq_levels u_levels (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (lvl_op),
        .sel     (sel),
        .stat    (lvl_stat)
    );

    mlpq_free u_free (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (fl_op),
        .stat    (fl_stat)
    );

    // Result beat
    always_comb begin
        out_next.key_out   = '0;
        out_next.level_out = '0;
        if (is_deq) begin
            out_next.status = lvl_stat.any ? mlpq_pkg::STATUS_DONE : mlpq_pkg::STATUS_EMPTY;
            if (lvl_stat.any) begin
                out_next.key_out   = mlpq_pkg::key_trunc(key_rd);
                out_next.level_out = mlpq_pkg::LEVEL_W'(lvl_stat.found);
            end
        end else if (lvl_ok && fl_stat.empty) begin
            out_next.status = mlpq_pkg::STATUS_FULL;
        end else begin
            out_next.status = mlpq_pkg::STATUS_DONE;
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        item_reg  <= s_data;
                        state_reg <= S_EXEC;
                    end
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        out_reg     <= out_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Every pool entry is either free or queued on some level
    `MLPQ_ASSERT_SAME(a_empty_pool_has_entries, aclk, aresetn, fl_stat.empty, lvl_stat.any)
    `MLPQ_ASSERT_SAME(a_no_levels_full_pool, aclk, aresetn, !lvl_stat.any, fl_stat.full)
    // An accepted item occupies the block: s_ready drops after the accept
    `MLPQ_ASSERT_NEXT(a_accept_then_busy, aclk, aresetn, accept, !s_ready)
    // A finished item always leaves a result beat behind
    `MLPQ_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, fire, m_valid)

endmodule
